[rtl/assert_macros.svh]
// Assertion macros used by the top level of the transform inverter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/rtiq_pkg.sv]
// Types and fixed constants of the rigid transform inverter.
package rtiq_pkg;

  localparam int MAG_W       = 31;
  localparam int SUM_W       = 64;
  localparam int ROOT_W      = 32;
  localparam int SQRT_STAGES = 32;

  typedef struct packed {
    logic signed [31:0] rot_00;
    logic signed [31:0] rot_01;
    logic signed [31:0] rot_02;
    logic signed [31:0] rot_10;
    logic signed [31:0] rot_11;
    logic signed [31:0] rot_12;
    logic signed [31:0] rot_20;
    logic signed [31:0] rot_21;
    logic signed [31:0] rot_22;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
  } in_t;

  typedef struct packed {
    logic        [30:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [31:0] inv_trans_x;
    logic signed [31:0] inv_trans_y;
    logic signed [31:0] inv_trans_z;
  } out_t;

  // Quaternion signs and the finished translation.
  typedef struct packed {
    logic        [3:0]  neg;
    logic signed [31:0] inv_x;
    logic signed [31:0] inv_y;
    logic signed [31:0] inv_z;
  } side2_t;

  typedef struct packed {
    logic [3:0][MAG_W-1:0] mag;
    side2_t                s2;
  } side1_t;

  typedef struct packed {
    side1_t            s1;
    logic [SUM_W-1:0]  sumsq;
  } front_t;

endpackage

[rtl/rtiq_front.sv]
// Front pipeline: Shepperd vector, magnitude scaling, sum of squares, inverted translation.
module rtiq_front import rtiq_pkg::*; #(
  parameter int FRAC_BITS = 30
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  in_t    in_data,
  output logic   out_valid,
  output front_t out_data
);

  localparam int VW = 36;
  localparam int SW = 67;
  localparam logic signed [VW-1:0] ONE  = VW'(64'd1 << FRAC_BITS);
  localparam logic signed [SW-1:0] HALF = SW'(64'd1 << (FRAC_BITS - 1));

  function automatic logic [5:0] msb35(input logic [34:0] x);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 35; i++) begin
      if (x[i]) p = 6'(i);
    end
    return p;
  endfunction

  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  // Stage 1: case select on M = R^T, translation products.
  logic signed [VW-1:0] m0, m1, m2, m3, m4, m5, m6, m7, m8, tr;
  logic signed [VW-1:0] vec_nxt [4];
  logic signed [VW-1:0] vec_r [4];
  logic signed [63:0]   prod_r [9];

  assign m0 = VW'(in_data.rot_00);
  assign m1 = VW'(in_data.rot_10);
  assign m2 = VW'(in_data.rot_20);
  assign m3 = VW'(in_data.rot_01);
  assign m4 = VW'(in_data.rot_11);
  assign m5 = VW'(in_data.rot_21);
  assign m6 = VW'(in_data.rot_02);
  assign m7 = VW'(in_data.rot_12);
  assign m8 = VW'(in_data.rot_22);
  assign tr = m0 + m4 + m8;

  always_comb begin
    priority if (tr > 0) begin
      vec_nxt[0] = ONE + tr;
      vec_nxt[1] = m7 - m5;
      vec_nxt[2] = m2 - m6;
      vec_nxt[3] = m3 - m1;
    end else if (m0 > m4 && m0 > m8) begin
      vec_nxt[0] = m7 - m5;
      vec_nxt[1] = ONE + m0 - m4 - m8;
      vec_nxt[2] = m1 + m3;
      vec_nxt[3] = m2 + m6;
    end else if (m4 > m8) begin
      vec_nxt[0] = m2 - m6;
      vec_nxt[1] = m1 + m3;
      vec_nxt[2] = ONE + m4 - m0 - m8;
      vec_nxt[3] = m5 + m7;
    end else begin
      vec_nxt[0] = m3 - m1;
      vec_nxt[1] = m2 + m6;
      vec_nxt[2] = m5 + m7;
      vec_nxt[3] = ONE + m8 - m0 - m4;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) vec_r[i] <= vec_nxt[i];
    prod_r[0] <= 64'(in_data.rot_00) * 64'(in_data.trans_x);
    prod_r[1] <= 64'(in_data.rot_10) * 64'(in_data.trans_y);
    prod_r[2] <= 64'(in_data.rot_20) * 64'(in_data.trans_z);
    prod_r[3] <= 64'(in_data.rot_01) * 64'(in_data.trans_x);
    prod_r[4] <= 64'(in_data.rot_11) * 64'(in_data.trans_y);
    prod_r[5] <= 64'(in_data.rot_21) * 64'(in_data.trans_z);
    prod_r[6] <= 64'(in_data.rot_02) * 64'(in_data.trans_x);
    prod_r[7] <= 64'(in_data.rot_12) * 64'(in_data.trans_y);
    prod_r[8] <= 64'(in_data.rot_22) * 64'(in_data.trans_z);
  end

  // Stage 2: magnitudes, largest magnitude, exact row sums.
  logic [34:0]          vmag_nxt [4];
  logic [34:0]          vmag_r [4];
  logic [34:0]          mx_nxt, mx_r;
  logic [3:0]           neg2_r;
  logic signed [SW-1:0] rsum_r [3];
  logic signed [VW-1:0] absv [4];

  always_comb begin
    mx_nxt = '0;
    for (int i = 0; i < 4; i++) begin
      absv[i]     = vec_r[i][VW-1] ? -vec_r[i] : vec_r[i];
      vmag_nxt[i] = absv[i][34:0];
      if (vmag_nxt[i] > mx_nxt) mx_nxt = vmag_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      vmag_r[i] <= vmag_nxt[i];
      neg2_r[i] <= vec_r[i][VW-1];
    end
    mx_r <= mx_nxt;
    for (int k = 0; k < 3; k++) begin
      rsum_r[k] <= SW'(prod_r[3*k]) + SW'(prod_r[3*k+1]) + SW'(prod_r[3*k+2]);
    end
  end

  // Stage 3: common scaling into [2^30, 2^31), translation rounding and saturation.
  logic [5:0]           pos;
  logic [5:0]           rsh, lsh;
  logic [34:0]          shifted [4];
  logic signed [SW-1:0] rnd [3];
  logic signed [31:0]   sat [3];
  logic [MAG_W-1:0]     mag3_r [4];
  logic [3:0]           neg3_r;
  logic signed [31:0]   inv3_r [3];

  always_comb begin
    pos = msb35(mx_r);
    rsh = (pos > 6'd30) ? 6'(pos - 6'd30) : 6'd0;
    lsh = (pos > 6'd30) ? 6'd0 : 6'(6'd30 - pos);
    for (int i = 0; i < 4; i++) begin
      shifted[i] = (vmag_r[i] >> rsh) << lsh;
    end
    for (int k = 0; k < 3; k++) begin
      // Round to nearest with ties toward plus infinity: floor((-sum + ONE/2) / ONE).
      rnd[k] = (-rsum_r[k] + HALF) >>> FRAC_BITS;
      if (rnd[k] > 67'sh7FFFFFFF) begin
        sat[k] = 32'sh7FFFFFFF;
      end else if (rnd[k] < -67'sh80000000) begin
        sat[k] = -32'sh80000000;
      end else begin
        sat[k] = rnd[k][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) mag3_r[i] <= shifted[i][MAG_W-1:0];
    neg3_r <= neg2_r;
    for (int k = 0; k < 3; k++) inv3_r[k] <= sat[k];
  end

  // Stage 4: squares. Stage 5: their sum.
  logic [2*MAG_W-1:0] sq_r [4];
  side1_t             side4_r, side4_nxt;
  front_t             out_r;

  always_comb begin
    for (int i = 0; i < 4; i++) side4_nxt.mag[i] = mag3_r[i];
    side4_nxt.s2.neg   = neg3_r;
    side4_nxt.s2.inv_x = inv3_r[0];
    side4_nxt.s2.inv_y = inv3_r[1];
    side4_nxt.s2.inv_z = inv3_r[2];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) sq_r[i] <= mag3_r[i] * mag3_r[i];
    side4_r      <= side4_nxt;
    out_r.s1     <= side4_r;
    out_r.sumsq  <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]) + SUM_W'(sq_r[3]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  assign out_valid = v5_r;
  assign out_data  = out_r;

endmodule

[rtl/rtiq_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
module rtiq_sqrt import rtiq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [SUM_W-1:0]  radicand,
  output logic              out_valid,
  output logic [ROOT_W-1:0] root
);

  logic [34:0]       rem_r  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_r [SQRT_STAGES];
  logic [SUM_W-1:0]  x_r    [SQRT_STAGES];
  logic              vld_r  [SQRT_STAGES];

  logic [34:0]       rem_p  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_p [SQRT_STAGES];
  logic [SUM_W-1:0]  x_p    [SQRT_STAGES];
  logic              vld_p  [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic [34:0] cat, trial;

    if (k == 0) begin : g_first
      assign rem_p[k]  = '0;
      assign root_p[k] = '0;
      assign x_p[k]    = radicand;
      assign vld_p[k]  = in_valid;
    end else begin : g_rest
      assign rem_p[k]  = rem_r[k-1];
      assign root_p[k] = root_r[k-1];
      assign x_p[k]    = x_r[k-1];
      assign vld_p[k]  = vld_r[k-1];
    end

    assign cat   = {rem_p[k][32:0], x_p[k][SUM_W-1 -: 2]};
    assign trial = {1'b0, root_p[k], 2'b01};

    always_ff @(posedge clk) begin
      if (cat >= trial) begin
        rem_r[k]  <= cat - trial;
        root_r[k] <= {root_p[k][ROOT_W-2:0], 1'b1};
      end else begin
        rem_r[k]  <= cat;
        root_r[k] <= {root_p[k][ROOT_W-2:0], 1'b0};
      end
      x_r[k] <= {x_p[k][SUM_W-3:0], 2'b00};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_p[k];
      end
    end
  end

  assign out_valid = vld_r[SQRT_STAGES-1];
  assign root      = root_r[SQRT_STAGES-1];

endmodule

[rtl/rtiq_div.sv]
// Pipelined four-lane restoring divider, one quotient bit per stage.
module rtiq_div import rtiq_pkg::*; #(
  parameter int FRAC_BITS = 30
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [3:0][SUM_W-1:0]    dividend,
  input  logic [ROOT_W-1:0]        divisor,
  output logic                     out_valid,
  output logic [3:0][FRAC_BITS:0]  quot
);

  // The quotient is known to fit in FRAC_BITS+1 bits, so the division starts there.
  localparam int NST = FRAC_BITS + 1;

  logic [3:0][ROOT_W-1:0]   rem_r [NST];
  logic [3:0][FRAC_BITS:0]  low_r [NST];
  logic [3:0][FRAC_BITS:0]  q_r   [NST];
  logic [ROOT_W-1:0]        d_r   [NST];
  logic                     vld_r [NST];

  logic [3:0][ROOT_W-1:0]   rem_p [NST];
  logic [3:0][FRAC_BITS:0]  low_p [NST];
  logic [3:0][FRAC_BITS:0]  q_p   [NST];
  logic [ROOT_W-1:0]        d_p   [NST];
  logic                     vld_p [NST];

  for (genvar j = 0; j < NST; j++) begin : g_stage
    if (j == 0) begin : g_first
      for (genvar l = 0; l < 4; l++) begin : g_lane
        assign rem_p[j][l] = ROOT_W'(dividend[l] >> NST);
        assign low_p[j][l] = dividend[l][FRAC_BITS:0];
      end
      assign q_p[j]   = '0;
      assign d_p[j]   = divisor;
      assign vld_p[j] = in_valid;
    end else begin : g_rest
      assign rem_p[j] = rem_r[j-1];
      assign low_p[j] = low_r[j-1];
      assign q_p[j]   = q_r[j-1];
      assign d_p[j]   = d_r[j-1];
      assign vld_p[j] = vld_r[j-1];
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane_op
      logic [ROOT_W:0] cat;
      assign cat = {rem_p[j][l], low_p[j][l][FRAC_BITS]};

      always_ff @(posedge clk) begin
        if (cat >= {1'b0, d_p[j]}) begin
          rem_r[j][l] <= ROOT_W'(cat - {1'b0, d_p[j]});
          q_r[j][l]   <= {q_p[j][l][FRAC_BITS-1:0], 1'b1};
        end else begin
          rem_r[j][l] <= cat[ROOT_W-1:0];
          q_r[j][l]   <= {q_p[j][l][FRAC_BITS-1:0], 1'b0};
        end
        low_r[j][l] <= {low_p[j][l][FRAC_BITS-1:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      d_r[j] <= d_p[j];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else begin
        vld_r[j] <= vld_p[j];
      end
    end
  end

  assign out_valid = vld_r[NST-1];
  assign quot      = q_r[NST-1];

endmodule

[rtl/rigid_transform_invert_to_quaternion.sv]
// Top level: inverts a rigid transform and turns its rotation into a unit quaternion.
//
// Input channel: a transaction is taken at a rising edge with start high and busy
// low. busy stays low: the pipeline takes one transform in every cycle.
// Result channel: out_valid is high for exactly one cycle with out_data; the
// receiver cannot stall, so nothing is ever held back.
// The path runs through five front stages (case select and products, magnitudes,
// scaling, squares, sum), 32 stages of square root, one dividend stage,
// ROT_FRAC_BITS + 1 divider stages and the output register. Throughput is one
// transform per cycle.
// Results leave in the order the transforms arrived.
// Synchronous reset clears every valid bit; transforms in flight are dropped
// and no result appears until a new transform has run through.
// The quaternion comes out in the rotation format (ROT_FRAC_BITS fraction bits)
// with w non-negative; the translation comes out in Q16.16, saturated.
`include "assert_macros.svh"

module rigid_transform_invert_to_quaternion import rtiq_pkg::*; #(
  parameter int ROT_FRAC_BITS = 30
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  localparam int F   = ROT_FRAC_BITS;
  localparam int LAT = F + 40;
  localparam logic [F:0] ONE = (F+1)'(64'd1 << F);
  localparam logic signed [31:0] ONE_S = 32'(ONE);

  logic   fr_valid;
  front_t fr_data;

  rtiq_front #(.FRAC_BITS(F)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start & ~busy),
    .in_data   (in_data),
    .out_valid (fr_valid),
    .out_data  (fr_data)
  );

  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;

  rtiq_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .radicand  (fr_data.sumsq),
    .out_valid (sq_valid),
    .root      (sq_root)
  );

  // Side data follows the square root stage by stage.
  side1_t sb1_r [SQRT_STAGES];

  always_ff @(posedge clk) begin
    sb1_r[0] <= fr_data.s1;
    for (int k = 1; k < SQRT_STAGES; k++) sb1_r[k] <= sb1_r[k-1];
  end

  // Dividend stage: magnitude scaled by ONE plus half the norm for rounding.
  logic [3:0][SUM_W-1:0] dvd_r;
  logic [ROOT_W-1:0]     n_r;
  logic                  dv_r;
  side2_t                sb2_r [F+2];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      dvd_r[i] <= (SUM_W'(sb1_r[SQRT_STAGES-1].mag[i]) << F) + SUM_W'(sq_root >> 1);
    end
    n_r      <= sq_root;
    sb2_r[0] <= sb1_r[SQRT_STAGES-1].s2;
    for (int k = 1; k < F + 2; k++) sb2_r[k] <= sb2_r[k-1];
  end

  logic                dq_valid;
  logic [3:0][F:0]     dq_quot;

  rtiq_div #(.FRAC_BITS(F)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv_r),
    .dividend  (dvd_r),
    .divisor   (n_r),
    .out_valid (dq_valid),
    .quot      (dq_quot)
  );

  // Clamp, apply signs so that w is non-negative, register the result.
  side2_t          sfin;
  logic [3:0][F:0] qc;
  out_t            out_nxt, out_r;
  logic            ov_r;

  always_comb begin
    sfin = sb2_r[F+1];
    for (int i = 0; i < 4; i++) begin
      qc[i] = (dq_quot[i] > ONE) ? ONE : dq_quot[i];
    end
    out_nxt.quat_w      = 31'(qc[0]);
    out_nxt.quat_x      = (sfin.neg[1] != sfin.neg[0]) ? -32'(qc[1]) : 32'(qc[1]);
    out_nxt.quat_y      = (sfin.neg[2] != sfin.neg[0]) ? -32'(qc[2]) : 32'(qc[2]);
    out_nxt.quat_z      = (sfin.neg[3] != sfin.neg[0]) ? -32'(qc[3]) : 32'(qc[3]);
    out_nxt.inv_trans_x = sfin.inv_x;
    out_nxt.inv_trans_y = sfin.inv_y;
    out_nxt.inv_trans_z = sfin.inv_z;
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      dv_r <= sq_valid;
      ov_r <= dq_valid;
    end
  end

  assign busy      = 1'b0;
  assign out_valid = ov_r;
  assign out_data  = out_r;

  `ASSERT_IMPL(a_latency, clk, rst_n, out_valid, $past(start, LAT))
  `ASSERT_IMPL(a_w_bound, clk, rst_n, out_valid, out_data.quat_w <= 31'(ONE))
  `ASSERT_IMPL(a_x_bound, clk, rst_n, out_valid, ($signed(out_data.quat_x) <= ONE_S) && ($signed(out_data.quat_x) >= -ONE_S))
  `ASSERT_NEXT(a_div_issue, clk, rst_n, sq_valid, dv_r)

endmodule

[tb/sv/rtiq_checker.sv]
// Checker for the transform inverter: predicts each pose result and compares it field by field.
module rtiq_checker import rtiq_pkg::*; #(
  parameter int ROT_FRAC_BITS = 30
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  in_t  in_data,
  input  logic out_valid,
  input  out_t out_data,
  output int   fail_count,
  output int   pending_poses,
  output int   done_poses
);

  out_t pose_queue[$];
  int   mismatch_count;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned root;
    longint unsigned bit_w;
    root  = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > x) bit_w >>= 2;
    while (bit_w != 0) begin
      if (x >= root + bit_w) begin
        x    = x - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else begin
        root >>= 1;
      end
      bit_w >>= 2;
    end
    return root;
  endfunction

  // One row of -M*t, rounded half up and saturated to Q16.16.
  function automatic logic [31:0] inv_row(longint r0, longint r1, longint r2,
                                          longint t0, longint t1, longint t2);
    longint          one_v;
    longint          prod[3];
    longint          hi;
    longint          res;
    longint unsigned lo;
    longint unsigned mask;
    one_v   = longint'(1) << ROT_FRAC_BITS;
    mask    = one_v - 1;
    prod[0] = r0 * t0;
    prod[1] = r1 * t1;
    prod[2] = r2 * t2;
    hi = 0;
    lo = 0;
    for (int j = 0; j < 3; j++) begin
      hi += prod[j] >>> ROT_FRAC_BITS;
      lo += longint'(prod[j]) & mask;
    end
    hi += longint'(lo >> ROT_FRAC_BITS);
    lo &= mask;
    if (lo == 0) begin
      res = -hi;
    end else begin
      res = -hi - 1;
      if (one_v - lo >= (one_v >> 1)) res++;
    end
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    return res[31:0];
  endfunction

  function automatic out_t predict_pose(in_t p);
    longint          one_v;
    longint          m[9];
    longint          t[3];
    longint          v[4];
    longint          trace;
    longint unsigned mag[4];
    longint unsigned peak;
    longint unsigned sumsq;
    longint unsigned norm;
    longint unsigned q;
    longint          s;
    logic            neg[4];
    int              rsh;
    int              lsh;
    logic [31:0]     comp[4];
    out_t            r;
    one_v = longint'(1) << ROT_FRAC_BITS;
    // The inverse rotation is the transpose.
    m[0] = p.rot_00; m[1] = p.rot_10; m[2] = p.rot_20;
    m[3] = p.rot_01; m[4] = p.rot_11; m[5] = p.rot_21;
    m[6] = p.rot_02; m[7] = p.rot_12; m[8] = p.rot_22;
    t[0] = p.trans_x; t[1] = p.trans_y; t[2] = p.trans_z;
    trace = m[0] + m[4] + m[8];
    if (trace > 0) begin
      v[0] = one_v + trace; v[1] = m[7] - m[5]; v[2] = m[2] - m[6]; v[3] = m[3] - m[1];
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      v[0] = m[7] - m[5]; v[1] = one_v + m[0] - m[4] - m[8];
      v[2] = m[1] + m[3]; v[3] = m[2] + m[6];
    end else if (m[4] > m[8]) begin
      v[0] = m[2] - m[6]; v[1] = m[1] + m[3];
      v[2] = one_v + m[4] - m[0] - m[8]; v[3] = m[5] + m[7];
    end else begin
      v[0] = m[3] - m[1]; v[1] = m[2] + m[6];
      v[2] = m[5] + m[7]; v[3] = one_v + m[8] - m[0] - m[4];
    end
    peak = 0;
    for (int i = 0; i < 4; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? -v[i] : v[i];
      if (mag[i] > peak) peak = mag[i];
    end
    rsh = 0;
    lsh = 0;
    while (peak >= (64'd1 << 31)) begin peak >>= 1; rsh++; end
    while (peak != 0 && peak < (64'd1 << 30)) begin peak <<= 1; lsh++; end
    sumsq = 0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = (mag[i] >> rsh) << lsh;
      sumsq += mag[i] * mag[i];
    end
    norm = int_sqrt(sumsq);
    for (int i = 0; i < 4; i++) begin
      q = 0;
      if (norm != 0) begin
        q = ((mag[i] << ROT_FRAC_BITS) + (norm >> 1)) / norm;
        if (q > one_v) q = one_v;
      end
      s = q;
      if (neg[i] != neg[0]) s = -s;
      comp[i] = s[31:0];
    end
    r.quat_w      = comp[0][30:0];
    r.quat_x      = comp[1];
    r.quat_y      = comp[2];
    r.quat_z      = comp[3];
    r.inv_trans_x = inv_row(m[0], m[1], m[2], t[0], t[1], t[2]);
    r.inv_trans_y = inv_row(m[3], m[4], m[5], t[0], t[1], t[2]);
    r.inv_trans_z = inv_row(m[6], m[7], m[8], t[0], t[1], t[2]);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endtask

  assign fail_count    = mismatch_count;
  assign pending_poses = pose_queue.size();

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      mismatch_count = 0;
      done_poses     = 0;
      pose_queue.delete();
    end else begin
      if (start && !busy) pose_queue = {pose_queue, predict_pose(in_data)};
      if (out_valid) begin
        if (pose_queue.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("result with no transaction waiting: %h", out_data);
        end else begin
          want = pose_queue.pop_front();
          done_poses++;
          check_field("quat_w", {1'b0, want.quat_w}, {1'b0, out_data.quat_w});
          check_field("quat_x", want.quat_x, out_data.quat_x);
          check_field("quat_y", want.quat_y, out_data.quat_y);
          check_field("quat_z", want.quat_z, out_data.quat_z);
          check_field("inv_trans_x", want.inv_trans_x, out_data.inv_trans_x);
          check_field("inv_trans_y", want.inv_trans_y, out_data.inv_trans_y);
          check_field("inv_trans_z", want.inv_trans_z, out_data.inv_trans_z);
        end
      end
    end
  end

endmodule

[tb/sv/tb.sv]
// Testbench top: drives poses into the transform inverter and gives the verdict.
module tb;
  import rtiq_pkg::*;

  localparam int FRAC = 30;
  localparam int ONE  = 1 << FRAC;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;
  int   fail_count;
  int   pending_poses;
  int   done_poses;
  int   sent_poses;
  int   idle_rate;

  rigid_transform_invert_to_quaternion #(.ROT_FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  rtiq_checker #(.ROT_FRAC_BITS(FRAC)) checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .fail_count(fail_count),
    .pending_poses(pending_poses), .done_poses(done_poses)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

  // Presents one pose at the falling edge and holds it until it is taken.
  task automatic send_pose(in_t p);
    while ($urandom_range(99) < idle_rate) begin
      start = 0;
      @(negedge clk);
    end
    start   = 1;
    in_data = p;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_poses++;
    @(negedge clk);
    start = 0;
  endtask

  function automatic in_t make_pose(int r[9], int tx, int ty, int tz);
    in_t p;
    p.rot_00 = r[0]; p.rot_01 = r[1]; p.rot_02 = r[2];
    p.rot_10 = r[3]; p.rot_11 = r[4]; p.rot_12 = r[5];
    p.rot_20 = r[6]; p.rot_21 = r[7]; p.rot_22 = r[8];
    p.trans_x = tx; p.trans_y = ty; p.trans_z = tz;
    return p;
  endfunction

  // A proper rotation from a random quaternion, with up to the given noise on each entry.
  function automatic in_t rotation_pose(int noise);
    real a, b, c, d, nrm;
    real e[9];
    int  r[9];
    a = $urandom_range(2000) - 1000.0;
    b = $urandom_range(2000) - 1000.0;
    c = $urandom_range(2000) - 1000.0;
    d = $urandom_range(2000) - 1000.0 + 0.5;
    nrm = $sqrt(a * a + b * b + c * c + d * d);
    a = a / nrm; b = b / nrm; c = c / nrm; d = d / nrm;
    e[0] = 1 - 2 * (c * c + d * d); e[1] = 2 * (b * c - a * d); e[2] = 2 * (b * d + a * c);
    e[3] = 2 * (b * c + a * d); e[4] = 1 - 2 * (b * b + d * d); e[5] = 2 * (c * d - a * b);
    e[6] = 2 * (b * d - a * c); e[7] = 2 * (c * d + a * b); e[8] = 1 - 2 * (b * b + c * c);
    for (int i = 0; i < 9; i++)
      r[i] = $rtoi(e[i] * ONE) + $signed($urandom_range(2 * noise)) - noise;
    if ($urandom_range(1))
      return make_pose(r, $urandom, $urandom, $urandom);
    return make_pose(r, $signed($urandom_range(2000000)) - 1000000,
                     $signed($urandom_range(2000000)) - 1000000,
                     $signed($urandom_range(2000000)) - 1000000);
  endfunction

  initial begin
    int   id[9], rx[9], ry[9], rz[9], zr[9], mx[9], mn[9], raw[9];
    in_t  p;
    int   kind;
    rst_n = 0;
    start = 0;
    in_data = '0;
    sent_poses = 0;
    idle_rate = 20;
    repeat (2) @(negedge clk);
    rst_n = 1;

    id = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
    rx = '{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};
    ry = '{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE};
    rz = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE};
    zr = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    mx = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
           32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
    mn = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
           32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000};
    // Identity and the half turns reach each of the four quaternion cases.
    send_pose(make_pose(id, 0, 0, 0));
    send_pose(make_pose(id, 32'h7fffffff, 32'h80000000, 65536));
    send_pose(make_pose(rx, 100, -100, 3));
    send_pose(make_pose(ry, -1, 1, 32'h7fffffff));
    send_pose(make_pose(rz, 32'h80000000, 32'h80000000, 32'h80000000));
    // A zero matrix has zero trace and ties on the diagonal.
    send_pose(make_pose(zr, 5, 6, 7));
    // Extreme entries drive the translation into saturation both ways.
    send_pose(make_pose(mx, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    send_pose(make_pose(mx, 32'h80000000, 32'h80000000, 32'h80000000));
    send_pose(make_pose(mn, 32'h80000000, 32'h80000000, 32'h80000000));
    send_pose(make_pose(mn, 32'h7fffffff, 32'h80000000, 32'h7fffffff));
    // Rounding ties on the translation.
    send_pose(make_pose('{ONE / 2, 0, 0, 0, ONE / 2, 0, 0, 0, ONE / 2}, 1, -1, 3));
    send_pose(make_pose('{-ONE / 2, 0, 0, 0, -ONE / 2, 0, 0, 0, -ONE / 2}, 1, -1, -3));
    // Zero scalar part with a negative sign decision, and a non-rotation matrix.
    send_pose(make_pose('{ONE, 5, 0, -5, -ONE, 0, 0, 0, -ONE}, 9, 9, 9));
    send_pose(make_pose('{0, ONE, 0, 0, 0, ONE, ONE, 0, 0}, -7, 8, -9));
    send_pose(make_pose('{3, -2, 1, 7, 7, 7, -9, 4, 7}, 1, 2, 3));

    for (int n = 0; n < 840; n++) begin
      // A long stretch with the sender never pausing.
      idle_rate = (n >= 300 && n < 450) ? 0 : 20;
      if (n == 600) begin
        start = 0;
        while (pending_poses != 0) @(negedge clk);
      end
      kind = $urandom_range(99);
      if (kind < 60) begin
        p = rotation_pose(kind < 30 ? 0 : 64);
      end else if (kind < 85) begin
        foreach (raw[i]) raw[i] = $urandom;
        p = make_pose(raw, $urandom, $urandom, $urandom);
      end else begin
        // Signed permutation matrices exercise the diagonal comparisons and ties.
        zr = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        kind = $urandom_range(5);
        for (int i = 0; i < 3; i++)
          zr[i * 3 + ((i + kind) % 3)] = $urandom_range(1) ? ONE : -ONE;
        p = make_pose(zr, $urandom, $urandom, $urandom);
      end
      send_pose(p);
    end

    while (pending_poses != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("Sent %0d poses (directed corners, rotations, raw matrices, permutations);",
             sent_poses);
    $display("%0d results checked, %0d field mismatches.", done_poses, fail_count);
    if (fail_count == 0 && pending_poses == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/rtiq_pkg.sv
rtl/rtiq_front.sv
rtl/rtiq_sqrt.sv
rtl/rtiq_div.sv
rtl/rigid_transform_invert_to_quaternion.sv
tb/sv/rtiq_checker.sv
tb/sv/tb.sv
